FILE: hw/rtl/etf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

    // Field widths of the block
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PIXEL_BITS = 12;
    localparam int COUNT_BITS = 16;

    // Derived widths
    localparam int DIM_BITS   = PIXEL_BITS + 1;            // screen size register
    localparam int STEP_BITS  = COORD_BITS + 1;            // edge difference and step
    localparam int Z_BITS     = COORD_BITS + 1;            // orbit value, -16.0 <= z < 16.0
    localparam int PROD_BITS  = STEP_BITS + DIM_BITS;      // step * pixel
    localparam int SUM_BITS   = PROD_BITS + 1;             // edge +/- step * pixel
    localparam int SQ_BITS    = 2 * Z_BITS - FRAC_BITS;    // floored square
    localparam int XY_BITS    = SQ_BITS + 1;               // floored 2*r*i

    // Configuration port
    localparam int CFG_DATA_BITS  = COORD_BITS;
    localparam int REG_INDEX_BITS = 3;

    localparam logic [REG_INDEX_BITS-1:0] REG_LEFT_EDGE       = REG_INDEX_BITS'(0);
    localparam logic [REG_INDEX_BITS-1:0] REG_RIGHT_EDGE      = REG_INDEX_BITS'(1);
    localparam logic [REG_INDEX_BITS-1:0] REG_TOP_EDGE        = REG_INDEX_BITS'(2);
    localparam logic [REG_INDEX_BITS-1:0] REG_BOTTOM_EDGE     = REG_INDEX_BITS'(3);
    localparam logic [REG_INDEX_BITS-1:0] REG_WIDTH_PIXELS    = REG_INDEX_BITS'(4);
    localparam logic [REG_INDEX_BITS-1:0] REG_HEIGHT_PIXELS   = REG_INDEX_BITS'(5);
    localparam logic [REG_INDEX_BITS-1:0] REG_ITERATION_LIMIT = REG_INDEX_BITS'(6);

    // Reset view: re -2.0 .. 1.0, im 1.25 .. -1.25, 640 x 480, 256 iterations
    localparam logic [COORD_BITS-1:0] LEFT_EDGE_RESET   = COORD_BITS'(-536870912);
    localparam logic [COORD_BITS-1:0] RIGHT_EDGE_RESET  = COORD_BITS'(268435456);
    localparam logic [COORD_BITS-1:0] TOP_EDGE_RESET    = COORD_BITS'(335544320);
    localparam logic [COORD_BITS-1:0] BOTTOM_EDGE_RESET = COORD_BITS'(-335544320);
    localparam logic [DIM_BITS-1:0]   WIDTH_RESET       = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]   HEIGHT_RESET      = DIM_BITS'(480);
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET       = COUNT_BITS'(256);

    // |z|^2 bailout, 4.0 in the fraction format of the squares
    localparam logic [SQ_BITS:0] ESCAPE_LEVEL =
        {{(SQ_BITS - FRAC_BITS - 2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    // One lane of the restoring divider
    typedef struct packed {
        logic [DIM_BITS-1:0]   rem;
        logic [COORD_BITS-1:0] dq;     // dividend bits shift out, quotient bits in
        logic [DIM_BITS-1:0]   den;
        logic                  neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t h;
        div_lane_t v;
    } div_pair_t;

    // Divider result handed to the orbit unit
    typedef struct packed {
        logic                        vld;
        logic signed [STEP_BITS-1:0] step_h;
        logic signed [STEP_BITS-1:0] step_v;
    } steps_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic [PIXEL_BITS-1:0] out_x;
        logic [PIXEL_BITS-1:0] out_y;
    } out_item_t;

    // One restoring division step
    function automatic div_lane_t div_step(input div_lane_t l);
        logic [DIM_BITS:0] part;
        div_lane_t         n;
        part = {l.rem, l.dq[COORD_BITS-1]};
        n    = l;
        if (part >= {1'b0, l.den})
        begin
            n.rem = DIM_BITS'(part - {1'b0, l.den});
            n.dq  = {l.dq[COORD_BITS-2:0], 1'b1};
        end
        else
        begin
            n.rem = part[DIM_BITS-1:0];
            n.dq  = {l.dq[COORD_BITS-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/etf_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit for both axes, registered.
module etf_div_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_vld,
    input  wire etf_pkg::div_pair_t in_pair,
    output logic                   out_vld,
    output etf_pkg::div_pair_t     out_pair
);
    import etf_pkg::*;

    logic      vld_reg;
    div_pair_t pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg.h <= div_step(in_pair.h);
        pair_reg.v <= div_step(in_pair.v);
    end

    assign out_vld  = vld_reg;
    assign out_pair = pair_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/etf_step_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel step sizes: (right-left)/width and (top-bottom)/height, truncated
// toward zero. Prep stage, one cell per quotient bit, then sign fixup.
module etf_step_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] left,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] right,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] top,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] bottom,
    input  wire logic        [etf_pkg::DIM_BITS-1:0]   width,
    input  wire logic        [etf_pkg::DIM_BITS-1:0]   height,
    output etf_pkg::steps_t                            steps
);
    import etf_pkg::*;

    logic                        prep_vld_reg;
    logic signed [STEP_BITS-1:0] diff_h_reg;
    logic signed [STEP_BITS-1:0] diff_v_reg;
    logic [DIM_BITS-1:0]         den_h_reg;
    logic [DIM_BITS-1:0]         den_v_reg;

    div_pair_t           link [0:COORD_BITS];
    logic [COORD_BITS:0] link_vld;

    logic                        steps_vld_reg;
    logic signed [STEP_BITS-1:0] step_h_reg;
    logic signed [STEP_BITS-1:0] step_v_reg;

    function automatic div_lane_t lane_init(input logic signed [STEP_BITS-1:0] diff,
                                            input logic [DIM_BITS-1:0] den);
        logic [STEP_BITS-1:0] mag;
        div_lane_t            l;
        mag   = diff[STEP_BITS-1] ? STEP_BITS'(-diff) : diff;
        l.rem = '0;
        l.dq  = mag[COORD_BITS-1:0];
        l.den = den;
        l.neg = diff[STEP_BITS-1];
        return l;
    endfunction

    function automatic logic [STEP_BITS-1:0] lane_result(input div_lane_t l);
        logic [STEP_BITS-1:0] q;
        q = {1'b0, l.dq};
        if (l.den == '0)
        begin
            return '0;
        end
        else if (l.neg)
        begin
            return STEP_BITS'(-q);
        end
        else
        begin
            return q;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg  <= 1'b0;
            steps_vld_reg <= 1'b0;
        end
        else
        begin
            prep_vld_reg  <= start;
            steps_vld_reg <= link_vld[COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        diff_h_reg <= {right[COORD_BITS-1], right} - {left[COORD_BITS-1], left};
        diff_v_reg <= {top[COORD_BITS-1], top} - {bottom[COORD_BITS-1], bottom};
        den_h_reg  <= width;
        den_v_reg  <= height;
        step_h_reg <= lane_result(link[COORD_BITS].h);
        step_v_reg <= lane_result(link[COORD_BITS].v);
    end

    assign link_vld[0] = prep_vld_reg;
    assign link[0]     = '{h: lane_init(diff_h_reg, den_h_reg),
                           v: lane_init(diff_v_reg, den_v_reg)};

    for (genvar k = 0; k < COORD_BITS; k++)
    begin : g_cell
        etf_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (link_vld[k]),
            .in_pair  (link[k]),
            .out_vld  (link_vld[k+1]),
            .out_pair (link[k+1])
        );
    end

    assign steps = '{vld: steps_vld_reg, step_h: step_h_reg, step_v: step_v_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/etf_orbit.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps the pixel onto c, then runs z = z*z + c one step per cycle.
module etf_orbit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire etf_pkg::steps_t                       steps,
    input  wire logic        [etf_pkg::PIXEL_BITS-1:0] px,
    input  wire logic        [etf_pkg::PIXEL_BITS-1:0] py,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] left,
    input  wire logic signed [etf_pkg::COORD_BITS-1:0] top,
    input  wire logic        [etf_pkg::COUNT_BITS-1:0] limit,
    input  wire logic                                  take,
    output logic                                       res_valid,
    output logic             [etf_pkg::COUNT_BITS-1:0] count
);
    import etf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_ITER,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic signed [PROD_BITS-1:0]  prod_re_reg;
    logic signed [PROD_BITS-1:0]  prod_im_reg;
    logic signed [COORD_BITS-1:0] cre_reg;
    logic signed [COORD_BITS-1:0] cim_reg;
    logic signed [Z_BITS-1:0]     r_reg;
    logic signed [Z_BITS-1:0]     i_reg;

    logic signed [PROD_BITS-1:0]  prod_re;
    logic signed [PROD_BITS-1:0]  prod_im;
    logic [SUM_BITS-1:0]          re_sum;
    logic [SUM_BITS-1:0]          im_sum;

    logic signed [2*Z_BITS-1:0]   rr_full;
    logic signed [2*Z_BITS-1:0]   ii_full;
    logic signed [2*Z_BITS-1:0]   ri_full;
    logic [SQ_BITS-1:0]           rs;
    logic [SQ_BITS-1:0]           is_sq;
    logic [XY_BITS-1:0]           ri2;
    logic [SQ_BITS:0]             mag2;
    logic                         escaped;
    logic                         stop;
    logic [SQ_BITS-1:0]           r_sum;
    logic [XY_BITS-1:0]           i_sum;
    logic [Z_BITS-1:0]            r_next;
    logic [Z_BITS-1:0]            i_next;

    function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [SUM_BITS-1:0] v);
        if (v[SUM_BITS-1:COORD_BITS-1] == {(SUM_BITS-COORD_BITS+1){v[SUM_BITS-1]}})
        begin
            return v[COORD_BITS-1:0];
        end
        else if (v[SUM_BITS-1])
        begin
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    endfunction

    // c = edge +/- step * pixel, saturated to the coordinate range
    assign prod_re = steps.step_h * $signed({1'b0, px});
    assign prod_im = steps.step_v * $signed({1'b0, py});
    assign re_sum  = {{(SUM_BITS-COORD_BITS){left[COORD_BITS-1]}}, left}
                   + {prod_re_reg[PROD_BITS-1], prod_re_reg};
    assign im_sum  = {{(SUM_BITS-COORD_BITS){top[COORD_BITS-1]}}, top}
                   - {prod_im_reg[PROD_BITS-1], prod_im_reg};

    // Floored products: the arithmetic shift rounds toward minus infinity
    assign rr_full = r_reg * r_reg;
    assign ii_full = i_reg * i_reg;
    assign ri_full = r_reg * i_reg;
    assign rs      = rr_full[2*Z_BITS-1:FRAC_BITS];
    assign is_sq   = ii_full[2*Z_BITS-1:FRAC_BITS];
    assign ri2     = ri_full[2*Z_BITS-1:FRAC_BITS-1];

    // squares are never negative
    assign mag2    = {1'b0, rs} + {1'b0, is_sq};
    assign escaped = (mag2 >= ESCAPE_LEVEL);
    assign stop    = escaped || (count_reg >= limit);

    assign r_sum   = rs - is_sq + {{(SQ_BITS-COORD_BITS){cre_reg[COORD_BITS-1]}}, cre_reg};
    assign i_sum   = ri2 + {{(XY_BITS-COORD_BITS){cim_reg[COORD_BITS-1]}}, cim_reg};
    assign r_next  = r_sum[Z_BITS-1:0];
    assign i_next  = i_sum[Z_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (steps.vld)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    count_reg <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (stop)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            prod_re_reg <= prod_re;
            prod_im_reg <= prod_im;
        end
        if (state_reg == S_SCALE)
        begin
            cre_reg <= clamp_coord(re_sum);
            cim_reg <= clamp_coord(im_sum);
            r_reg   <= '0;
            i_reg   <= '0;
        end
        else if (state_reg == S_ITER && !stop)
        begin
            r_reg <= r_next;
            i_reg <= i_next;
        end
    end

    assign res_valid = (state_reg == S_DONE);
    assign count     = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_data  : pixel_x, pixel_y
// out      out  out_valid/out_ready  out_data : iteration_count, out_x, out_y
// cfg      in   cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One pixel at a time: the next pixel is taken once the result of the last
// one has moved into the output register. A pixel passes through the step
// divider chain (one cell per quotient bit), the mapping onto the plane and
// the orbit unit (one z step per cycle).
// Reset restores the default view and drops any pixel in flight.
// out_ready low holds the result in the output register; the next pixel
// still computes and waits in the orbit unit until the register frees up.
module escape_time_fractal_pixel (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // pixel in
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire etf_pkg::in_item_t                        in_data,
    // count out
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output etf_pkg::out_item_t                            out_data,
    // configuration writes
    input  wire logic                                     cfg_we,
    input  wire logic [etf_pkg::REG_INDEX_BITS-1:0]       cfg_index,
    input  wire logic [etf_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
    import etf_pkg::*;

    // configuration registers
    logic signed [COORD_BITS-1:0] left_reg;
    logic signed [COORD_BITS-1:0] right_reg;
    logic signed [COORD_BITS-1:0] top_reg;
    logic signed [COORD_BITS-1:0] bottom_reg;
    logic [DIM_BITS-1:0]          width_reg;
    logic [DIM_BITS-1:0]          height_reg;
    logic [COUNT_BITS-1:0]        limit_reg;

    // pixel in flight
    logic                  busy_reg;
    logic [PIXEL_BITS-1:0] px_reg;
    logic [PIXEL_BITS-1:0] py_reg;

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic                  in_xfer;
    steps_t                steps;
    logic                  res_valid;
    logic [COUNT_BITS-1:0] res_count;
    logic                  load;

    assign in_ready = !busy_reg;
    assign in_xfer  = in_valid && in_ready;

    // finished count moves to the output register when it is empty or draining
    assign load = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= LEFT_EDGE_RESET;
            right_reg  <= RIGHT_EDGE_RESET;
            top_reg    <= TOP_EDGE_RESET;
            bottom_reg <= BOTTOM_EDGE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_EDGE:       left_reg   <= cfg_data;
                REG_RIGHT_EDGE:      right_reg  <= cfg_data;
                REG_TOP_EDGE:        top_reg    <= cfg_data;
                REG_BOTTOM_EDGE:     bottom_reg <= cfg_data;
                REG_WIDTH_PIXELS:    width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_HEIGHT_PIXELS:   height_reg <= cfg_data[DIM_BITS-1:0];
                REG_ITERATION_LIMIT: limit_reg  <= cfg_data[COUNT_BITS-1:0];
                default:             ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= in_data.pixel_x;
            py_reg <= in_data.pixel_y;
        end
        if (load)
        begin
            out_data_reg.iteration_count <= res_count;
            out_data_reg.out_x           <= px_reg;
            out_data_reg.out_y           <= py_reg;
        end
    end

    etf_step_div u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_xfer),
        .left   (left_reg),
        .right  (right_reg),
        .top    (top_reg),
        .bottom (bottom_reg),
        .width  (width_reg),
        .height (height_reg),
        .steps  (steps)
    );

    etf_orbit u_orbit (
        .clk       (clk),
        .rst_n     (rst_n),
        .steps     (steps),
        .px        (px_reg),
        .py        (py_reg),
        .left      (left_reg),
        .top       (top_reg),
        .limit     (limit_reg),
        .take      (load),
        .res_valid (res_valid),
        .count     (res_count)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/etf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module etf_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire etf_pkg::in_item_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire etf_pkg::out_item_t out_data
);
    import etf_pkg::*;

    logic [1:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;
    in_item_t   last_in;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign last_in  = in_data;

    // transfers in minus transfers out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted pixel");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready && last_in == $past(last_in) || !in_ready)
        else $error("second pixel taken while one is in flight");

    a_two_pending_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !in_ready)
        else $error("input open with a result waiting and a pixel in flight");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !out_valid |=> !out_valid)
        else $error("result appeared right after the pixel transfer");

endmodule

bind escape_time_fractal_pixel etf_checker u_etf_checker (.*);

`default_nettype wire
